// ===== sv/three_plane_intersection_top_defines.svh =====
// Assertion macros for the three-plane intersection block.
// Used by three_plane_intersection_top; needs i_clk and i_rst_n in scope.
`ifndef THREE_PLANE_INTERSECTION_TOP_DEFINES_SVH
`define THREE_PLANE_INTERSECTION_TOP_DEFINES_SVH

// same-cycle implication
`define TPI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tpi assertion failed");

// next-cycle implication
`define TPI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tpi assertion failed");

`endif

// ===== sv/tpi_pkg.sv =====
// Types and widths for the three-plane intersection pipeline.
// No dependencies.
package tpi_pkg;

    localparam int NRM_W  = 16;
    localparam int OFS_W  = 32;
    localparam int CW     = 33;
    localparam int PDW    = 49;
    localparam int DETW   = 51;
    localparam int PNW    = 65;
    localparam int SUMW   = 67;
    localparam int MAGW   = 66;
    localparam int AW     = 51;
    localparam int DVW    = 52;
    localparam int NW     = 83;
    localparam int RW     = 53;
    localparam int QW     = 32;
    localparam int FRAC_SH = 15;
    localparam int DIV_STEPS = 32;

    localparam logic [QW-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [QW-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic signed [NRM_W-1:0] plane_a_nx;
        logic signed [NRM_W-1:0] plane_a_ny;
        logic signed [NRM_W-1:0] plane_a_nz;
        logic signed [OFS_W-1:0] plane_a_offset;
        logic signed [NRM_W-1:0] plane_b_nx;
        logic signed [NRM_W-1:0] plane_b_ny;
        logic signed [NRM_W-1:0] plane_b_nz;
        logic signed [OFS_W-1:0] plane_b_offset;
        logic signed [NRM_W-1:0] plane_c_nx;
        logic signed [NRM_W-1:0] plane_c_ny;
        logic signed [NRM_W-1:0] plane_c_nz;
        logic signed [OFS_W-1:0] plane_c_offset;
    } t_in;

    typedef struct packed {
        logic                    valid_res;
        logic signed [OFS_W-1:0] point_x;
        logic signed [OFS_W-1:0] point_y;
        logic signed [OFS_W-1:0] point_z;
    } t_out;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QW-1:0] num;
        logic [QW-1:0] q;
    } t_lane;

endpackage

// ===== sv/tpi_div_stage.sv =====
// One restoring-division step of one coordinate lane, registered.
// Depends on tpi_pkg.
module tpi_div_stage (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [tpi_pkg::DVW-1:0] i_d,
    input  tpi_pkg::t_lane       i_lane,
    output tpi_pkg::t_lane       o_lane
);
    import tpi_pkg::*;

    logic [RW-1:0] trial;
    logic          take;
    t_lane         n_lane;
    t_lane         r_lane;

    always_comb begin
        trial        = {i_lane.rem[RW-2:0], i_lane.num[QW-1]};
        take         = trial >= RW'(i_d);
        n_lane.rem   = take ? trial - RW'(i_d) : trial;
        n_lane.num   = {i_lane.num[QW-2:0], 1'b0};
        n_lane.q     = {i_lane.q[QW-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// ===== sv/three_plane_intersection_top.sv =====
// Three-plane intersection by Cramer's rule, fixed point, fully pipelined.
// Accepts one transaction per cycle unless i_out_ready back-pressure fills the pipeline.
// Depth is set by 32 one-bit restoring division stages per coordinate.
// Each stage holds its item when the next is full and stalled; bubbles collapse.
// Synchronous active-low reset clears all stage valid bits.
// Depends on tpi_pkg, tpi_div_stage and three_plane_intersection_top_defines.svh.
`include "three_plane_intersection_top_defines.svh"

module three_plane_intersection_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tpi_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tpi_pkg::t_out o_out_data
);
    import tpi_pkg::*;

    localparam int NS = 6 + DIV_STEPS + 1;

    logic r_v [0:NS-1];
    logic w_en [0:NS];

    t_in r_in;
    t_in r1_in;
    logic signed [CW-1:0] r_bc [0:2];
    logic signed [CW-1:0] r_ca [0:2];
    logic signed [CW-1:0] r_ab [0:2];
    logic signed [PDW-1:0] r_pd [0:2];
    logic signed [PNW-1:0] r_pn [0:2][0:2];
    logic signed [DETW-1:0] r_det;
    logic signed [SUMW-1:0] r_sum [0:2];
    logic [NW-1:0] r_num4 [0:2];
    logic [DVW-1:0] r_d4;
    logic [2:0] r_neg4;
    logic r_zero4;

    logic [DVW-1:0] r_dd [0:DIV_STEPS];
    logic [2:0] r_neg [0:DIV_STEPS];
    logic [2:0] r_ovf [0:DIV_STEPS];
    logic r_zero [0:DIV_STEPS];
    t_lane r_lane0 [0:2];
    t_lane w_lane [0:DIV_STEPS][0:2];

    t_out r_out;
    t_out n_out;

    always_comb begin
        w_en[NS] = i_out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 0: input register
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_in <= i_in_data;
        end
    end

    // stage 1: cross products
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_in    <= r_in;
            r_bc[0] <= CW'(r_in.plane_b_ny) * CW'(r_in.plane_c_nz)
                     - CW'(r_in.plane_b_nz) * CW'(r_in.plane_c_ny);
            r_bc[1] <= CW'(r_in.plane_b_nz) * CW'(r_in.plane_c_nx)
                     - CW'(r_in.plane_b_nx) * CW'(r_in.plane_c_nz);
            r_bc[2] <= CW'(r_in.plane_b_nx) * CW'(r_in.plane_c_ny)
                     - CW'(r_in.plane_b_ny) * CW'(r_in.plane_c_nx);
            r_ca[0] <= CW'(r_in.plane_c_ny) * CW'(r_in.plane_a_nz)
                     - CW'(r_in.plane_c_nz) * CW'(r_in.plane_a_ny);
            r_ca[1] <= CW'(r_in.plane_c_nz) * CW'(r_in.plane_a_nx)
                     - CW'(r_in.plane_c_nx) * CW'(r_in.plane_a_nz);
            r_ca[2] <= CW'(r_in.plane_c_nx) * CW'(r_in.plane_a_ny)
                     - CW'(r_in.plane_c_ny) * CW'(r_in.plane_a_nx);
            r_ab[0] <= CW'(r_in.plane_a_ny) * CW'(r_in.plane_b_nz)
                     - CW'(r_in.plane_a_nz) * CW'(r_in.plane_b_ny);
            r_ab[1] <= CW'(r_in.plane_a_nz) * CW'(r_in.plane_b_nx)
                     - CW'(r_in.plane_a_nx) * CW'(r_in.plane_b_nz);
            r_ab[2] <= CW'(r_in.plane_a_nx) * CW'(r_in.plane_b_ny)
                     - CW'(r_in.plane_a_ny) * CW'(r_in.plane_b_nx);
        end
    end

    // stage 2: determinant and numerator products
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_pd[0] <= PDW'(r1_in.plane_a_nx) * PDW'(r_bc[0]);
            r_pd[1] <= PDW'(r1_in.plane_a_ny) * PDW'(r_bc[1]);
            r_pd[2] <= PDW'(r1_in.plane_a_nz) * PDW'(r_bc[2]);
            for (int i = 0; i < 3; i++) begin
                r_pn[i][0] <= PNW'(r1_in.plane_a_offset) * PNW'(r_bc[i]);
                r_pn[i][1] <= PNW'(r1_in.plane_b_offset) * PNW'(r_ca[i]);
                r_pn[i][2] <= PNW'(r1_in.plane_c_offset) * PNW'(r_ab[i]);
            end
        end
    end

    // stage 3: sums
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_det <= DETW'(r_pd[0]) + DETW'(r_pd[1]) + DETW'(r_pd[2]);
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= SUMW'(r_pn[i][0]) + SUMW'(r_pn[i][1]) + SUMW'(r_pn[i][2]);
            end
        end
    end

    // stage 4: magnitudes, signs, rounding bias
    logic            w_dneg;
    logic [AW-1:0]   w_ad;
    logic [MAGW-1:0] w_mag [0:2];

    always_comb begin
        w_dneg = r_det[DETW-1];
        w_ad   = w_dneg ? AW'(-r_det) : AW'(r_det);
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_sum[i][SUMW-1] ? MAGW'(-r_sum[i]) : MAGW'(r_sum[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_zero4 <= (r_det == '0);
            r_d4    <= {w_ad, 1'b0};
            for (int i = 0; i < 3; i++) begin
                r_neg4[i]  <= (!r_sum[i][SUMW-1] && (r_sum[i] != '0)) != w_dneg;
                r_num4[i]  <= NW'({w_mag[i], {FRAC_SH{1'b0}}}) + NW'(w_ad);
            end
        end
    end

    // stage 5: overflow check and division setup
    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_dd[0]   <= r_d4;
            r_neg[0]  <= r_neg4;
            r_zero[0] <= r_zero4;
            for (int i = 0; i < 3; i++) begin
                r_ovf[0][i]   <= r_num4[i] >= NW'({r_d4, {(QW-1){1'b0}}});
                r_lane0[i].rem <= RW'(r_num4[i][NW-1:QW]);
                r_lane0[i].num <= r_num4[i][QW-1:0];
                r_lane0[i].q   <= '0;
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane0
        assign w_lane[0][i] = r_lane0[i];
    end

    // stages 6..37: one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        for (genvar i = 0; i < 3; i++) begin : g_axis
            tpi_div_stage u_step (
                .i_clk  (i_clk),
                .i_en   (w_en[6+k]),
                .i_d    (r_dd[k]),
                .i_lane (w_lane[k][i]),
                .o_lane (w_lane[k+1][i])
            );
        end

        always_ff @(posedge i_clk) begin
            if (w_en[6+k]) begin
                r_dd[k+1]   <= r_dd[k];
                r_neg[k+1]  <= r_neg[k];
                r_ovf[k+1]  <= r_ovf[k];
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    // stage 38: sign, saturation, output register
    logic [QW-1:0] w_res [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_zero[DIV_STEPS]) begin
                w_res[i] = '0;
            end else if (r_ovf[DIV_STEPS][i]) begin
                w_res[i] = r_neg[DIV_STEPS][i] ? SAT_NEG : SAT_POS;
            end else if (r_neg[DIV_STEPS][i]) begin
                w_res[i] = QW'(-w_lane[DIV_STEPS][i].q);
            end else begin
                w_res[i] = w_lane[DIV_STEPS][i].q;
            end
        end
        n_out.valid_res = !r_zero[DIV_STEPS];
        n_out.point_x   = w_res[0];
        n_out.point_y   = w_res[1];
        n_out.point_z   = w_res[2];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_v[NS-1];
    assign o_out_data  = r_out;

    `TPI_ASSERT_IMP(a_invalid_zero, o_out_valid && !o_out_data.valid_res, (o_out_data.point_x == '0) && (o_out_data.point_y == '0) && (o_out_data.point_z == '0))
    `TPI_ASSERT_IMP(a_rem_below_div, r_v[5] && !r_zero[0] && !r_ovf[0][0], r_lane0[0].rem < RW'(r_dd[0]))
    `TPI_ASSERT_IMP(a_ready_when_drained, !o_out_valid, o_in_ready)
    `TPI_ASSERT_NXT(a_stalled_holds, o_out_valid && !i_out_ready && r_v[NS-2], r_v[NS-2])

endmodule
